// ===== hdl/w36_pkg.sv =====
// ---------------------------------------------------------------------------
// w36_pkg: shared types and constants of the 36-bit arithmetic unit
// Word widths, operation codes and the structs that travel down the chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package w36_pkg;

   localparam int WORD_BITS  = 36;
   localparam int MAG_BITS   = WORD_BITS - 1;
   localparam int PROD_BITS  = 2 * WORD_BITS - 1;
   localparam int CELL_COUNT = WORD_BITS;

   typedef logic [WORD_BITS-1:0] word_type;

   localparam word_type SIGN_WORD = word_type'(1) << MAG_BITS;

   typedef enum logic [2:0] {
      KIND_ADD  = 3'd0,
      KIND_SUB  = 3'd1,
      KIND_SMUL = 3'd2,
      KIND_DMUL = 3'd3,
      KIND_SDIV = 3'd4,
      KIND_DDIV = 3'd5
   } kind_type;

   // Per-word control and early result carried alongside the datapath
   typedef struct packed {
      logic [2:0] kind;
      logic       qneg;    // product or quotient is negative
      logic       rneg;    // remainder takes a negative sign
      logic       spec;    // double multiply of two most-negative words
      logic       early;   // result already known at entry
      word_type   rh;
      word_type   rl;
      logic       ov;
      logic       c0;
      logic       c1;
      logic       nd;
   } side_type;

   // One chain stage: operand m, partial remainder or product high, shift word
   typedef struct packed {
      side_type       side;
      word_type       m;
      logic [WORD_BITS:0] hi;
      word_type       lo;
   } cell_type;

endpackage

`default_nettype wire

// ===== hdl/word36_arith_unit.sv =====
// ---------------------------------------------------------------------------
// word36_arith_unit: 36-bit two's complement add, subtract, multiply, divide
//
//   channel | dir | words carried
//   req_    | in  | kind in tuser; operand_a_high, operand_a_low, operand_b
//   rsp_    | out | result_high, result_low and five per-operation flags
//
// One word enters per cycle unless the result side stalls; each result passes
// through one entry stage, 36 multiply/divide cells and one output register.
// Every operation, add included, runs the full chain so order is kept.
// Reset empties the chain. A stalled result register halts the whole chain
// and drops req_tready in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module word36_arith_unit import w36_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [111:0] req_tdata,   // operand_a_high, operand_a_low, operand_b, pad
   input  wire logic [2:0]   req_tuser,   // kind
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [79:0]       rsp_tdata    // result_high, result_low, overflow,
                                          // trap_one, carry_zero, carry_one, no_divide, pad
);

   logic      en;
   logic      chain_valid [0:CELL_COUNT];
   cell_type  chain_data  [0:CELL_COUNT];
   word_type  rh, rl;
   logic      ov, c0, c1, nd;

   // Advance the chain whenever the output register is free or drains
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   w36_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .kind     (req_tuser),
      .a        (req_tdata[WORD_BITS-1:0]),
      .al       (req_tdata[2*WORD_BITS-1:WORD_BITS]),
      .b        (req_tdata[3*WORD_BITS-1:2*WORD_BITS]),
      .valid_ff (chain_valid[0]),
      .data_ff  (chain_data[0])
   );

   // Row of step cells
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      w36_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (chain_valid[i]),
         .in_data  (chain_data[i]),
         .valid_ff (chain_valid[i+1]),
         .data_ff  (chain_data[i+1])
      );
   end

   w36_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (chain_valid[CELL_COUNT]),
      .in_data  (chain_data[CELL_COUNT]),
      .valid_ff (rsp_tvalid),
      .rh_ff    (rh),
      .rl_ff    (rl),
      .ov_ff    (ov),
      .c0_ff    (c0),
      .c1_ff    (c1),
      .nd_ff    (nd)
   );

   assign rsp_tdata = {3'b000, nd, c1, c0, ov, ov, rl, rh};

   // Checks on the result flags and pipeline control
   a_nd_sets_ov: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && nd |-> ov)
      else $error("no_divide raised without overflow");

   a_no_carry_on_div: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && nd |-> !c0 && !c1)
      else $error("carry flag raised on a refused divide");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rh) && $stable(rl))
      else $error("held result changed while stalled");

endmodule

`default_nettype wire

// ===== hdl/w36_prep.sv =====
// ---------------------------------------------------------------------------
// w36_prep: entry stage
// Decodes the operation, forms magnitudes, resolves add, subtract and
// refused divides, and loads the first chain stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module w36_prep import w36_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     in_valid,
   input  wire logic [2:0] kind,
   input  wire word_type a,
   input  wire word_type al,
   input  wire word_type b,
   output logic          valid_ff,
   output cell_type      data_ff
);

   cell_type              data_in;
   logic                  valid_in;
   word_type              a_neg, b_neg, a_mag, b_mag, mh;
   logic [MAG_BITS-1:0]   l_neg, ml;
   logic [WORD_BITS:0]    sum_w, diff_w;

   // Form magnitudes and the doubleword dividend
   always_comb begin
      a_neg  = ~a + word_type'(1);
      b_neg  = ~b + word_type'(1);
      a_mag  = a[MAG_BITS] ? a_neg : a;
      b_mag  = b[MAG_BITS] ? b_neg : b;
      l_neg  = ~al[MAG_BITS-1:0] + MAG_BITS'(1);
      sum_w  = {1'b0, a} + {1'b0, b};
      diff_w = {a[MAG_BITS], a} - {b[MAG_BITS], b};
      if (a[MAG_BITS]) begin
         mh = (al[MAG_BITS-1:0] != '0) ? ~a : a_neg;
         ml = l_neg;
      end else begin
         mh = a;
         ml = al[MAG_BITS-1:0];
      end
   end

   // Decode the operation
   always_comb begin
      data_in = '0;
      data_in.side.kind = kind;
      unique case (kind) inside
         KIND_ADD: begin
            data_in.side.early = 1'b1;
            data_in.side.rh    = sum_w[WORD_BITS-1:0];
            data_in.side.c0    = sum_w[WORD_BITS];
            data_in.side.c1    = sum_w[MAG_BITS] ^ a[MAG_BITS] ^ b[MAG_BITS];
            data_in.side.ov    = data_in.side.c0 ^ data_in.side.c1;
         end
         KIND_SUB: begin
            data_in.side.early = 1'b1;
            data_in.side.rh    = diff_w[WORD_BITS-1:0];
            data_in.side.ov    = diff_w[WORD_BITS] ^ diff_w[MAG_BITS];
            data_in.side.c0    = data_in.side.ov & diff_w[WORD_BITS];
            data_in.side.c1    = data_in.side.ov & ~diff_w[WORD_BITS];
         end
         KIND_SMUL, KIND_DMUL: begin
            data_in.m         = a_mag;
            data_in.lo        = b_mag;
            data_in.side.qneg = a[MAG_BITS] ^ b[MAG_BITS];
            data_in.side.spec = (kind == KIND_DMUL) && (a == SIGN_WORD) && (b == SIGN_WORD);
         end
         KIND_SDIV: begin
            data_in.m         = b_mag;
            data_in.lo        = a_mag;
            data_in.side.qneg = a[MAG_BITS] ^ b[MAG_BITS];
            data_in.side.rneg = a[MAG_BITS];
            if (b == '0 || (a == SIGN_WORD && b == '1)) begin
               data_in.side.early = 1'b1;
               data_in.side.nd    = 1'b1;
               data_in.side.ov    = 1'b1;
               data_in.side.rh    = a;
               data_in.side.rl    = b;
            end
         end
         KIND_DDIV: begin
            data_in.m         = b_mag;
            data_in.hi        = {2'b00, mh[WORD_BITS-1:1]};
            data_in.lo        = {mh[0], ml};
            data_in.side.qneg = a[MAG_BITS] ^ b[MAG_BITS];
            data_in.side.rneg = a[MAG_BITS];
            if (mh >= b_mag) begin
               data_in.side.early = 1'b1;
               data_in.side.nd    = 1'b1;
               data_in.side.ov    = 1'b1;
               data_in.side.rh    = a;
               data_in.side.rl    = al;
            end
         end
         default: begin
            data_in.side.early = 1'b1;
         end
      endcase
   end

   assign valid_in = in_valid;

   // Load the first stage when the chain advances
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/w36_cell.sv =====
// ---------------------------------------------------------------------------
// w36_cell: one step of the shift-add multiply or restoring divide
// Each cell retires one multiplier bit or one quotient bit and hands the
// partial state to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module w36_cell import w36_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     in_valid,
   input  wire cell_type in_data,
   output logic          valid_ff,
   output cell_type      data_ff
);

   cell_type           data_in;
   logic [WORD_BITS:0] add_w, shl_w, sub_w;
   logic               q_bit;

   // Step the multiply or divide
   always_comb begin
      data_in = in_data;
      add_w   = in_data.hi + (in_data.lo[0] ? {1'b0, in_data.m} : '0);
      shl_w   = {in_data.hi[WORD_BITS-1:0], in_data.lo[WORD_BITS-1]};
      sub_w   = shl_w - {1'b0, in_data.m};
      q_bit   = (shl_w >= {1'b0, in_data.m});
      if (in_data.side.kind[2]) begin
         data_in.hi = q_bit ? sub_w : shl_w;
         data_in.lo = {in_data.lo[WORD_BITS-2:0], q_bit};
      end else begin
         data_in.hi = {1'b0, add_w[WORD_BITS:1]};
         data_in.lo = {add_w[0], in_data.lo[WORD_BITS-1:1]};
      end
   end

   // Advance to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/w36_finish.sv =====
// ---------------------------------------------------------------------------
// w36_finish: result stage
// Applies signs, picks the result words and flags, and holds the word
// on the result channel until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module w36_finish import w36_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire logic     in_valid,
   input  wire cell_type in_data,
   output logic          valid_ff,
   output word_type      rh_ff,
   output word_type      rl_ff,
   output logic          ov_ff,
   output logic          c0_ff,
   output logic          c1_ff,
   output logic          nd_ff
);

   logic [PROD_BITS-1:0] prod, prod_t;
   logic                 neg;
   word_type             quot, rem, rh_in, rl_in;
   logic                 ov_in, c0_in, c1_in, nd_in;
   side_type             sd;

   // Sign the product, quotient and remainder
   always_comb begin
      sd     = in_data.side;
      prod   = {in_data.hi[MAG_BITS-1:0], in_data.lo};
      neg    = sd.qneg && (prod != '0);
      prod_t = neg ? (~prod + PROD_BITS'(1)) : prod;
      quot   = sd.qneg ? (~in_data.lo + word_type'(1)) : in_data.lo;
      rem    = sd.rneg ? (~in_data.hi[WORD_BITS-1:0] + word_type'(1))
                       : in_data.hi[WORD_BITS-1:0];
   end

   // Select result words and flags
   always_comb begin
      rh_in = sd.rh;
      rl_in = sd.rl;
      ov_in = sd.ov;
      c0_in = sd.c0;
      c1_in = sd.c1;
      nd_in = sd.nd;
      if (!sd.early) begin
         case (sd.kind)
            KIND_SMUL: begin
               rh_in = {neg, prod_t[MAG_BITS-1:0]};
               rl_in = '0;
               ov_in = neg ? ((prod[PROD_BITS-1:WORD_BITS] != '0)
                             || (prod[MAG_BITS] && prod[MAG_BITS-1:0] != '0))
                           : (prod[PROD_BITS-1:MAG_BITS] != '0);
            end
            KIND_DMUL: begin
               if (sd.spec) begin
                  rh_in = SIGN_WORD;
                  rl_in = SIGN_WORD;
                  ov_in = 1'b1;
               end else begin
                  rh_in = prod_t[PROD_BITS-1:MAG_BITS];
                  rl_in = {neg, prod_t[MAG_BITS-1:0]};
               end
            end
            default: begin
               rh_in = quot;
               rl_in = rem;
            end
         endcase
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rh_ff <= rh_in;
         rl_ff <= rl_in;
         ov_ff <= ov_in;
         c0_ff <= c0_in;
         c1_ff <= c1_in;
         nd_ff <= nd_in;
      end
   end

endmodule

`default_nettype wire

// ===== tb/word36_arith_unit_tb.sv =====
// ---------------------------------------------------------------------------
// word36_arith_unit_tb: self-checking bench for the 36-bit arithmetic unit
// Drives operand words with random gaps, predicts each result in the bench
// and compares every returned word field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module word36_arith_unit_tb import w36_pkg::*; ();

   localparam word_type   ALL_ONES  = {WORD_BITS{1'b1}};
   localparam word_type   MAX_POS   = SIGN_WORD - 1;
   localparam logic [2:0] KIND_NONE6 = 3'd6;
   localparam logic [2:0] KIND_NONE7 = 3'd7;
   localparam int         RANDOM_WORDS = 650;
   localparam longint     CYCLE_LIMIT  = 200000;

   typedef struct packed {
      word_type rh;
      word_type rl;
      logic     ov;
      logic     t1;
      logic     c0;
      logic     c1;
      logic     nd;
   } result_type;

   // Scoreboard: computes the expected result of each accepted word
   class arith_scoreboard;
      result_type pending[$];
      int         mismatches;
      int         checked;
      int         per_kind[8];

      function longint sext(word_type v);
         return longint'(v[MAG_BITS-1:0]) - (v[MAG_BITS] ? longint'(1) <<< MAG_BITS : 0);
      endfunction

      function longint unsigned magn(longint s);
         return s < 0 ? longint'(-s) : s;
      endfunction

      function result_type compute(logic [2:0] k, word_type a, word_type al, word_type b);
         result_type r;
         longint sa, sb, d;
         longint unsigned ma, mb, mh, ml, rem, q, l;
         logic [71:0] prod, tp;
         logic neg, dneg;
         r = '0;
         sa = sext(a);
         sb = sext(b);
         case (k)
            KIND_ADD: begin
               r.rh = a + b;
               r.c0 = 1'(({1'b0, a} + {1'b0, b}) >> WORD_BITS);
               r.c1 = 1'(({1'b0, a[MAG_BITS-1:0]} + {1'b0, b[MAG_BITS-1:0]}) >> MAG_BITS);
               r.ov = r.c0 != r.c1;
            end
            KIND_SUB: begin
               d = sa - sb;
               r.rh = word_type'(d);
               if (d < -(longint'(1) <<< MAG_BITS)) begin
                  r.ov = 1'b1; r.c0 = 1'b1;
               end else if (d >= (longint'(1) <<< MAG_BITS)) begin
                  r.ov = 1'b1; r.c1 = 1'b1;
               end
            end
            KIND_SMUL, KIND_DMUL: begin
               ma = magn(sa);
               mb = magn(sb);
               prod = 72'(ma) * 72'(mb);
               neg = ((sa < 0) != (sb < 0)) && prod != 0;
               tp = neg ? -prod : prod;
               if (k == KIND_SMUL) begin
                  r.rh = {neg, tp[MAG_BITS-1:0]};
                  r.ov = neg ? (prod > 72'(SIGN_WORD)) : (prod >= 72'(SIGN_WORD));
               end else if (a == SIGN_WORD && b == SIGN_WORD) begin
                  r.rh = SIGN_WORD; r.rl = SIGN_WORD; r.ov = 1'b1;
               end else begin
                  r.rh = tp[70:35];
                  r.rl = {neg, tp[34:0]};
               end
            end
            KIND_SDIV: begin
               if (b == 0 || (a == SIGN_WORD && b == ALL_ONES)) begin
                  r.nd = 1'b1; r.ov = 1'b1; r.rh = a; r.rl = b;
               end else begin
                  r.rh = word_type'(sa / sb);
                  r.rl = word_type'(sa % sb);
               end
            end
            KIND_DDIV: begin
               l = al[MAG_BITS-1:0];
               mb = magn(sb);
               dneg = sa < 0;
               if (dneg) begin
                  mh = l != 0 ? magn(sa) - 1 : magn(sa);
                  ml = l != 0 ? longint'(SIGN_WORD) - l : 0;
               end else begin
                  mh = sa; ml = l;
               end
               if (mh >= mb) begin
                  r.nd = 1'b1; r.ov = 1'b1; r.rh = a; r.rl = al;
               end else begin
                  rem = mh; q = 0;
                  for (int i = MAG_BITS - 1; i >= 0; i--) begin
                     rem = (rem << 1) | ((ml >> i) & 1);
                     if (rem >= mb) begin
                        rem -= mb; q |= longint'(1) << i;
                     end
                  end
                  r.rh = (dneg != (sb < 0)) ? -word_type'(q) : word_type'(q);
                  r.rl = dneg ? -word_type'(rem) : word_type'(rem);
               end
            end
            default: ;
         endcase
         r.t1 = r.ov;
         return r;
      endfunction

      function void note_operands(logic [2:0] k, word_type a, word_type al, word_type b);
         pending.push_back(compute(k, a, al, b));
         per_kind[k]++;
      endfunction

      function void check_result(logic [79:0] data);
         result_type got, exp;
         got = {data[35:0], data[71:36], data[72], data[73], data[74], data[75], data[76]};
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", data);
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch #%0d: rh %h/%h rl %h/%h ov %b/%b t1 %b/%b",
                         " c0 %b/%b c1 %b/%b nd %b/%b (exp/got)"},
                  checked, exp.rh, got.rh, exp.rl, got.rl, exp.ov, got.ov, exp.t1, got.t1,
                  exp.c0, got.c0, exp.c1, got.c1, exp.nd, got.nd);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [79:0]  rsp_tdata;

   arith_scoreboard board = new();
   longint cycles = 0;

   always #4 clock = ~clock;

   word36_arith_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // End the run if the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Note accepted words and check returned ones
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_operands(req_tuser, req_tdata[35:0], req_tdata[71:36], req_tdata[107:72]);
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata);
   end

   // Stall the result side for a random gap before each word
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         repeat (gap) begin
            rsp_tready <= 0;
            @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock iff rsp_tvalid);
      end
   end

   task automatic send_word(logic [2:0] k, word_type a, word_type al, word_type b);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= k;
      req_tdata  <= {4'b0, b, al, a};
      @(posedge clock iff req_tready);
   endtask

   function automatic word_type rand_word();
      word_type w;
      case ($urandom_range(0, 5))
         0: w = SIGN_WORD;
         1: w = MAX_POS;
         2: w = ALL_ONES;
         3: w = word_type'($urandom_range(0, 40));
         4: w = -word_type'($urandom_range(0, 40));
         default: w = word_type'({$urandom, $urandom});
      endcase
      return w;
   endfunction

   // Double divides mostly get a high word below the divisor so they rarely refuse
   task automatic send_random();
      logic [2:0] k;
      word_type a, al, b;
      k  = 3'($urandom_range(0, 7));
      a  = rand_word();
      al = word_type'({$urandom, $urandom});
      b  = rand_word();
      if (k == KIND_DDIV && $urandom_range(0, 3) != 0) begin
         b = word_type'({$urandom, $urandom});
         a[MAG_BITS] = 1'($urandom_range(0, 1));
         a[MAG_BITS-1:0] = b[MAG_BITS-1:0] >> ($urandom_range(1, 34));
      end
      send_word(k, a, al, b);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: field extremes and each special case
      send_word(KIND_ADD,  MAX_POS, 0, 1);
      send_word(KIND_ADD,  SIGN_WORD, 0, ALL_ONES);
      send_word(KIND_ADD,  ALL_ONES, ALL_ONES, ALL_ONES);
      send_word(KIND_SUB,  SIGN_WORD, 0, 1);
      send_word(KIND_SUB,  MAX_POS, 0, ALL_ONES);
      send_word(KIND_SUB,  0, 0, SIGN_WORD);
      send_word(KIND_SMUL, SIGN_WORD, 0, ALL_ONES);
      send_word(KIND_SMUL, SIGN_WORD, 0, 1);
      send_word(KIND_SMUL, MAX_POS, 0, MAX_POS);
      send_word(KIND_DMUL, SIGN_WORD, 0, SIGN_WORD);
      send_word(KIND_DMUL, SIGN_WORD, 0, MAX_POS);
      send_word(KIND_DMUL, 0, 0, ALL_ONES);
      send_word(KIND_SDIV, 5, 0, 0);
      send_word(KIND_SDIV, SIGN_WORD, 0, ALL_ONES);
      send_word(KIND_SDIV, -word_type'(7), 0, 2);
      send_word(KIND_SDIV, MAX_POS, 0, SIGN_WORD);
      send_word(KIND_DDIV, 0, 123, 0);
      send_word(KIND_DDIV, 1, ALL_ONES, 3);
      send_word(KIND_DDIV, ALL_ONES, SIGN_WORD | 9, -word_type'(4));
      send_word(KIND_DDIV, 0, 0, 1);
      send_word(KIND_DDIV, 3, 0, 3);
      send_word(KIND_NONE6, ALL_ONES, ALL_ONES, ALL_ONES);
      send_word(KIND_NONE7, 1, 1, 1);
      for (int i = 0; i < RANDOM_WORDS; i++) send_random();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("checked %0d results: add %0d sub %0d smul %0d dmul %0d sdiv %0d ddiv %0d",
         board.checked, board.per_kind[0], board.per_kind[1], board.per_kind[2],
         board.per_kind[3], board.per_kind[4], board.per_kind[5]);
      $display("unused kinds %0d, mismatches %0d",
         board.per_kind[6] + board.per_kind[7], board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/w36_pkg.sv
hdl/w36_prep.sv
hdl/w36_cell.sv
hdl/w36_finish.sv
hdl/word36_arith_unit.sv
tb/word36_arith_unit_tb.sv
